>>> sv/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

  localparam int RRTS_MAX_TASKS = 128;
  localparam int GROUP          = 16;
  localparam int GROUP_BITS     = 4;

  typedef enum logic [2:0] {
    OC_SWITCHED = 3'd0,
    OC_NO_TASKS = 3'd1,
    OC_NO_READY = 3'd2,
    OC_CREATED  = 3'd3,
    OC_BUSY     = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_TICK,
    ST_SCAN,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  task_id;
    logic [31:0] context_ptr;
  } req_t;

  typedef struct packed {
    logic [31:0] next_ptr;
    logic [6:0]  next_task;
    outcome_t    outcome;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic create;
    logic no_tasks;
    logic tick_start;
    logic scan;
    logic read;
    logic switch_res;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_tasks;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/rrts_ctrl.sv
`default_nettype none
module rrts_ctrl import rrts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  input  wire logic      req_is_tick,
  output logic           req_stall,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = req_is_tick ? ST_TICK : ST_CREATE;
        end
      end
      ST_CREATE: begin
        cmd.create = 1'b1;
        state_next = ST_EMIT;
      end
      ST_TICK: begin
        if (stat.no_tasks) begin
          cmd.no_tasks = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          cmd.tick_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = ST_READ;
        end else if (stat.last) begin
          state_next = ST_EMIT;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.switch_res = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.emit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> sv/rrts_dp.sv
`default_nettype none
module rrts_dp import rrts_pkg::*; #(
  parameter int MAX_TASKS = RRTS_MAX_TASKS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      req,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       stat,
  output rsp_t           rsp
);

  localparam int IW   = $clog2(MAX_TASKS);
  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam int NCH  = (MAX_TASKS + GROUP - 1) / GROUP;
  localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SW   = $clog2(NCH + 1);
  localparam int PADW = NCH * GROUP;
  localparam int PW   = $clog2(PADW);

  req_t                  req_q;
  logic [MAX_TASKS-1:0]  ready;
  logic [31:0]           ctx_mem [MAX_TASKS];
  logic [31:0]           rdata;
  logic [IW-1:0]         cur;
  logic [CNTW-1:0]       count;
  logic [CW-1:0]         chunk;
  logic [SW-1:0]         step;
  logic [IW-1:0]         found;
  rsp_t                  res;
  rsp_t                  out_q;

  logic [IW-1:0]         slot;
  logic                  busy;
  logic [IW-1:0]         hi;
  logic [PADW-1:0]       ready_pad;
  logic [GROUP-1:0]      window;
  logic [GROUP-1:0]      elig;
  logic [PW-1:0]         pos [GROUP];
  logic [IW-1:0]         hit_slot;
  logic                  we;
  logic [IW-1:0]         waddr;

  // create checks
  always_comb begin
    slot = IW'(req_q.task_id);
    busy = ({25'd0, req_q.task_id} >= 32'(MAX_TASKS)) || ready[slot];
  end

  // scan window: one group of slots per cycle, lowest eligible wins
  always_comb begin
    hi        = (count > CNTW'(MAX_TASKS - 1)) ? IW'(MAX_TASKS - 1) : IW'(count);
    ready_pad = PADW'(ready);
    window    = ready_pad[chunk*GROUP +: GROUP];
    hit_slot  = '0;
    for (int j = 0; j < GROUP; j++) begin
      pos[j]  = PW'(int'(chunk) * GROUP + j);
      elig[j] = window[j] && (pos[j] != '0) && (pos[j] <= PW'(hi));
      if (step == '0) begin
        elig[j] = elig[j] && (pos[j] > PW'(cur));
      end else if (step == SW'(NCH)) begin
        elig[j] = elig[j] && (pos[j] <= PW'(cur));
      end
    end
    for (int j = GROUP - 1; j >= 0; j--) begin
      if (elig[j]) begin
        hit_slot = IW'(pos[j]);
      end
    end
  end

  assign stat.no_tasks = (count == '0);
  assign stat.hit      = |elig;
  assign stat.last     = (step == SW'(NCH));

  assign we    = (cmd.create && !busy) || cmd.tick_start;
  assign waddr = cmd.create ? slot : cur;

  always_ff @(posedge clk) begin
    if (we) begin
      ctx_mem[waddr] <= req_q.context_ptr;
    end
    if (cmd.read) begin
      rdata <= ctx_mem[found];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
      cur   <= '0;
      count <= '0;
      chunk <= '0;
      step  <= '0;
    end else begin
      if (cmd.create && !busy) begin
        ready[slot] <= 1'b1;
        if (count != CNTW'(MAX_TASKS)) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.tick_start) begin
        chunk <= CW'(PW'(cur) >> GROUP_BITS);
        step  <= '0;
      end else if (cmd.scan) begin
        chunk <= (chunk == CW'(NCH - 1)) ? '0 : chunk + 1'b1;
        step  <= step + 1'b1;
      end
      if (cmd.read) begin
        cur <= found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.scan && stat.hit) begin
      found <= hit_slot;
    end
    if (cmd.create) begin
      res <= '{next_ptr: req_q.context_ptr, next_task: 7'(cur),
               outcome: busy ? OC_BUSY : OC_CREATED};
    end else if (cmd.no_tasks) begin
      res <= '{next_ptr: req_q.context_ptr, next_task: 7'(cur), outcome: OC_NO_TASKS};
    end else if (cmd.scan && !stat.hit && stat.last) begin
      res <= '{next_ptr: req_q.context_ptr, next_task: 7'(cur), outcome: OC_NO_READY};
    end else if (cmd.switch_res) begin
      res <= '{next_ptr: rdata, next_task: 7'(cur), outcome: OC_SWITCHED};
    end
    if (cmd.emit) begin
      out_q <= res;
    end
  end

  assign rsp = out_q;

endmodule
`default_nettype wire

>>> sv/round_robin_task_switcher.sv
// order: a create goes through CREATE then EMIT, an empty-table tick through TICK then EMIT;
// a tick that scans walks one group of 16 ready flags per cycle in SCAN,
// then on a switch goes through READ, LOAD and EMIT
// or goes straight to EMIT when no slot is ready
// throughput: one transaction at a time, the next accepted the cycle after the result loads
// reset: rst synchronous, clears ready flags, task count and current task, no clearing pass
`default_nettype none
module round_robin_task_switcher import rrts_pkg::*; #(
  parameter int MAX_TASKS = RRTS_MAX_TASKS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rrts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_is_tick (req.cmd),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

  // one transaction in flight
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while busy");

  // a result only appears while an item is being worked on
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without item");

  // no switch result unless the walk found a slot
  assert property (@(posedge clk) disable iff (rst)
    cmd.switch_res |-> $past(cmd.read, 1) && $past(stat.hit, 2))
    else $error("switch without hit");

endmodule
`default_nettype wire

>>> tb/round_robin_task_switcher_tb.sv
`timescale 1ns / 100ps
module round_robin_task_switcher_tb;
  import rrts_pkg::*;

  localparam int   MAX_SLOTS  = RRTS_MAX_TASKS;
  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;
  localparam int   N_RANDOM   = 2000;
  localparam int   HOLD_AT    = 700;
  localparam int   HOLD_LEN   = 300;

  class task_switch_sb;
    bit          ready_flag [MAX_SLOTS];
    bit   [31:0] ctx_ptr [MAX_SLOTS];
    bit   [6:0]  cur_task;
    int          n_tasks;
    int          n_accepted;
    int          errors;
    int          longest_scan;
    int          seen [8];
    rsp_t        pending_rsp [$];

    function rsp_t predict_switch(req_t r);
      rsp_t p;
      int   hi;
      int   slot;
      int   n;
      bit   found;
      p.next_ptr  = r.context_ptr;
      p.next_task = cur_task;
      if (r.cmd == CMD_CREATE) begin
        if (int'(r.task_id) >= MAX_SLOTS || ready_flag[r.task_id]) begin
          p.outcome = OC_BUSY;
        end else begin
          ready_flag[r.task_id] = 1'b1;
          ctx_ptr[r.task_id]    = r.context_ptr;
          if (n_tasks < MAX_SLOTS) n_tasks++;
          p.outcome = OC_CREATED;
        end
      end else if (n_tasks == 0) begin
        p.outcome = OC_NO_TASKS;
      end else begin
        ctx_ptr[cur_task] = r.context_ptr;
        hi = (n_tasks > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : n_tasks;
        slot = int'(cur_task);
        found = 1'b0;
        p.outcome = OC_NO_READY;
        for (n = 1; n <= hi && !found; n++) begin
          slot++;
          if (slot > hi) slot = 1;
          if (ready_flag[slot]) begin
            found       = 1'b1;
            cur_task    = slot[6:0];
            p.next_ptr  = ctx_ptr[slot];
            p.next_task = slot[6:0];
            p.outcome   = OC_SWITCHED;
            if (n > longest_scan) longest_scan = n;
          end
        end
      end
      return p;
    endfunction

    function void note_request(req_t r);
      rsp_t p;
      p = predict_switch(r);
      seen[int'(p.outcome)]++;
      pending_rsp.push_back(p);
      n_accepted++;
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: expected none, got %h/%0d/%0d", $time,
                 got.next_ptr, got.next_task, got.outcome);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.next_ptr !== want.next_ptr) begin
        errors++;
        $display("%0t next_ptr mismatch: expected %h, got %h", $time,
                 want.next_ptr, got.next_ptr);
      end
      if (got.next_task !== want.next_task) begin
        errors++;
        $display("%0t next_task mismatch: expected %0d, got %0d", $time,
                 want.next_task, got.next_task);
      end
      if (got.outcome !== want.outcome) begin
        errors++;
        $display("%0t outcome mismatch: expected %0d, got %0d", $time,
                 want.outcome, got.outcome);
      end
    endfunction

    function int free_slot(int start);
      int j;
      int id;
      for (j = 0; j < MAX_SLOTS; j++) begin
        id = (start + j) % MAX_SLOTS;
        if (!ready_flag[id]) return id;
      end
      return start;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  task_switch_sb sb = new;

  round_robin_task_switcher i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // stretch with no idling on either side
  function automatic bit quiet_window(int n);
    return n >= 1000 && n < 1300;
  endfunction

  function automatic req_t make_req(logic cmd, logic [6:0] id, logic [31:0] ptr);
    req_t r;
    r.cmd         = cmd;
    r.task_id     = id;
    r.context_ptr = ptr;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    while (!quiet_window(sb.n_accepted) && $urandom_range(99) < 13) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // receiver side, with one long hold-off so the block backs up
  initial begin : rx_side
    int hold_left;
    bit held;
    rsp_stall = 1'b0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.n_accepted >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet_window(sb.n_accepted) && ($urandom_range(99) < 13);
      end
    end
  end

  initial begin : stimulus
    int   i;
    int   id;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table, then sparse table with no ready slot in scan range
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_0000));
    send_req(make_req(CMD_TICK,   7'd127, 32'hFFFF_FFFF));
    send_req(make_req(CMD_CREATE, 7'd0,   32'h0000_1000));
    send_req(make_req(CMD_TICK,   7'd0,   32'hAAAA_5555));
    send_req(make_req(CMD_CREATE, 7'd127, 32'hFFFF_FFFF));
    send_req(make_req(CMD_CREATE, 7'd127, 32'h0000_0000));
    send_req(make_req(CMD_CREATE, 7'd0,   32'h0000_0001));
    send_req(make_req(CMD_TICK,   7'd64,  32'h5555_AAAA));
    // switching and wraparound
    send_req(make_req(CMD_CREATE, 7'd2,   32'h0000_2000));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_0001));
    send_req(make_req(CMD_CREATE, 7'd1,   32'h1000_0001));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_2222));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_1111));
    send_req(make_req(CMD_TICK,   7'd0,   32'h8000_0000));
    send_req(make_req(CMD_CREATE, 7'd1,   32'h7FFF_FFFF));
    send_req(make_req(CMD_CREATE, 7'd64,  32'h0640_0640));
    send_req(make_req(CMD_CREATE, 7'd5,   32'h0000_0505));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_0A0A));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_0B0B));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_0C0C));
    send_req(make_req(CMD_TICK,   7'd0,   32'h0000_0D0D));

    for (i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(99) < 12) begin
        id = $urandom_range(MAX_SLOTS - 1);
        if ($urandom_range(2) == 0 || i > 1600) id = sb.free_slot(id);
        send_req(make_req(CMD_CREATE, id[6:0], $urandom()));
      end else begin
        send_req(make_req(CMD_TICK, 7'($urandom_range(127)), $urandom()));
      end
    end
    req_valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("%0d transactions: %0d switched, %0d no tasks, %0d no ready, %0d created, %0d busy",
             sb.n_accepted, sb.seen[OC_SWITCHED], sb.seen[OC_NO_TASKS],
             sb.seen[OC_NO_READY], sb.seen[OC_CREATED], sb.seen[OC_BUSY]);
    $display("task count ended at %0d of %0d slots, longest scan %0d slots",
             sb.n_tasks, MAX_SLOTS, sb.longest_scan);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> round_robin_task_switcher.f
sv/rrts_pkg.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_task_switcher.sv
tb/round_robin_task_switcher_tb.sv
